// File: rtl/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// shared types, constants and the exp table entry function for the
// heisenberg metropolis site update unit
// ----------------------------------------------------------------------------
package hms_pkg;

	localparam int SPIN_W    = 16;
	localparam int MAG_W     = 28;
	localparam int SPIN_ONE  = 16384;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int EXP_W     = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BETA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS = 2'd2;

	typedef logic signed [SPIN_W-1:0] spin_t;
	typedef logic signed [MAG_W-1:0]  mag_t;

	// exp(-16k/n) in q1.16, f is k/n in q1.30
	function automatic logic [EXP_W-1:0] exp_from_f(input logic [63:0] f);
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        v;
		term = 64'd1 << 30;
		acc  = 64'sd1 <<< 30;
		for (int n = 1; n <= 24; n++) begin
			term = ((term * f) >> 30) / 64'(n);
			if (n % 2 == 1) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (64'sd1 <<< 30)) begin
			acc = 64'sd1 <<< 30;
		end
		v = 64'(acc);
		for (int i = 0; i < 4; i++) begin
			v = (v * v) >> 30;
		end
		return EXP_W'((v + 64'd8192) >> 14);
	endfunction

endpackage

// File: rtl/hms_if.sv
// ----------------------------------------------------------------------------
// hms channel interfaces
// proposal request, site result and configuration write channels
// ----------------------------------------------------------------------------
interface hms_req_if import hms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	spin_t               prop_x;
	spin_t               prop_y;
	spin_t               prop_z;
	logic [SPIN_W-1:0]   uniform;

	modport source (output valid, mode, prop_x, prop_y, prop_z, uniform, input ready);
	modport sink   (input valid, mode, prop_x, prop_y, prop_z, uniform, output ready);
endinterface

interface hms_rsp_if import hms_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [5:0] site_row;
	logic [5:0] site_col;
	logic       accepted;
	logic       sweep_done;
	mag_t       mag_x;
	mag_t       mag_y;
	mag_t       mag_z;

	modport source (output valid, site_row, site_col, accepted, sweep_done,
		mag_x, mag_y, mag_z, input ready);
	modport sink   (input valid, site_row, site_col, accepted, sweep_done,
		mag_x, mag_y, mag_z, output ready);
endinterface

interface hms_cfg_if import hms_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/heisenberg_metropolis_site_update_unit.sv
// ----------------------------------------------------------------------------
// heisenberg metropolis site update unit
// metropolis update of a periodic square lattice of 3-component spins,
// one site per request in raster order, with one shared multiplier
// ----------------------------------------------------------------------------
// sequence: a proposal makes 5 spin reads (centre, then the four neighbours),
//   works the energy and table index on the shared multiplier, then table
//   read, compare, write back and result; it ends early, accepted, when the
//   energy does not rise, or rejected when the argument is beyond the table;
//   a direct write reads only the centre spin and skips the arithmetic
// throughput: one request at a time, set by the single shared multiplier
//   and the single read port of the spin ram
// reset: control cleared and sums set at once, then a clearing pass sets every
//   spin to (0,0,1); no request is taken meanwhile, configuration writes are
module heisenberg_metropolis_site_update_unit import hms_pkg::*; #(
	parameter int LATTICE_SIDE      = 16,
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	hms_req_if.sink   req,
	hms_rsp_if.source rsp,
	hms_cfg_if.sink   cfg
);

	localparam int SITES  = LATTICE_SIDE * LATTICE_SIDE;
	localparam int ADDR_W = $clog2(SITES);
	localparam int ROW_W  = $clog2(LATTICE_SIDE);
	localparam int IDX_W  = $clog2(EXP_TABLE_ENTRIES);
	localparam int RAM_W  = 3 * SPIN_W;

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CALC  = 3'd3;
	localparam logic [2:0] S_EXP   = 3'd4;
	localparam logic [2:0] S_CMP   = 3'd5;
	localparam logic [2:0] S_WRITE = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	// exp table, built at elaboration
	logic [EXP_W-1:0] exp_rom [EXP_TABLE_ENTRIES];

	for (genvar k = 0; k < EXP_TABLE_ENTRIES; k++) begin : g_exp
		localparam logic [63:0] F = (64'(k) << 30) / EXP_TABLE_ENTRIES;
		assign exp_rom[k] = exp_from_f(F);
	end

	// control state
	logic [2:0]        state_q;
	logic [3:0]        cnt_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] site_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  col_q;
	logic              ovalid_q;

	// configuration
	logic [15:0]       beta_q;
	logic signed [3:0] exch_q;
	logic signed [3:0] axis_q;

	// request and working registers
	logic              mode_q;
	spin_t             nx_q, ny_q, nz_q;
	logic [15:0]       uni_q;
	spin_t             ox_q, oy_q, oz_q;
	logic signed [17:0] sx_q, sy_q, sz_q;
	logic signed [41:0] prod_q;
	logic signed [21:0] ax_q, ay_q;
	logic signed [22:0] bz_q;
	logic signed [39:0] acc_q;
	logic [35:0]        xlo_q;
	logic [54:0]        x_q;
	logic [12:0]        t_q;
	logic [IDX_W-1:0]   idx_q;
	logic [EXP_W-1:0]   rom_q;
	logic               accept_q;
	mag_t               sum_x_q, sum_y_q, sum_z_q;

	// result registers
	logic [5:0] orow_q, ocol_q;
	logic       oacc_q, olast_q;
	mag_t       omx_q, omy_q, omz_q;

	// spin ram
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [RAM_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [RAM_W-1:0]  ram_rdata;

	hms_ram #(
		.WIDTH (RAM_W),
		.DEPTH (SITES)
	) u_spin_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// wrapped neighbour addresses
	logic [ADDR_W-1:0] up_addr, dn_addr, lf_addr, rt_addr;

	always_comb begin
		up_addr = (row_q == '0) ? site_q + ADDR_W'(SITES - LATTICE_SIDE)
			: site_q - ADDR_W'(LATTICE_SIDE);
		dn_addr = (row_q == ROW_W'(LATTICE_SIDE - 1)) ? ADDR_W'(col_q)
			: site_q + ADDR_W'(LATTICE_SIDE);
		lf_addr = (col_q == '0) ? site_q + ADDR_W'(LATTICE_SIDE - 1) : site_q - 1'b1;
		rt_addr = (col_q == ROW_W'(LATTICE_SIDE - 1)) ? site_q - ADDR_W'(LATTICE_SIDE - 1)
			: site_q + 1'b1;
	end

	always_comb begin
		case (cnt_q)
			4'd1:    ram_raddr = up_addr;
			4'd2:    ram_raddr = dn_addr;
			4'd3:    ram_raddr = lf_addr;
			4'd4:    ram_raddr = rt_addr;
			default: ram_raddr = site_q;
		endcase
	end

	// write side: clearing pass or write back of an accepted spin
	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WRITE && accept_q);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : site_q;
	assign ram_wdata = (state_q == S_CLEAR) ? {32'd0, SPIN_W'(SPIN_ONE)} : {nx_q, ny_q, nz_q};

	// spin differences and coefficients
	logic signed [16:0] dx, dy, dz, zsum;
	logic signed [4:0]  a_coef, b2_coef;

	assign dx      = 17'(nx_q) - 17'(ox_q);
	assign dy      = 17'(ny_q) - 17'(oy_q);
	assign dz      = 17'(nz_q) - 17'(oz_q);
	assign zsum    = 17'(nz_q) + 17'(oz_q);
	assign a_coef  = 5'sd1 - 5'(exch_q);
	assign b2_coef = {axis_q, 1'b0};

	// shared multiplier operand select
	logic signed [23:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [41:0] mul_p;

	always_comb begin
		case (cnt_q)
			4'd0: begin
				mul_a = 24'(dx);
				mul_b = 18'(a_coef);
			end
			4'd1: begin
				mul_a = 24'(dy);
				mul_b = 18'(a_coef);
			end
			4'd2: begin
				mul_a = 24'(zsum);
				mul_b = 18'(b2_coef);
			end
			4'd3: begin
				mul_a = 24'(ax_q);
				mul_b = sx_q;
			end
			4'd4: begin
				mul_a = 24'(ay_q);
				mul_b = sy_q;
			end
			4'd5: begin
				mul_a = 24'(dz);
				mul_b = sz_q;
			end
			4'd6: begin
				mul_a = 24'(bz_q);
				mul_b = 18'(dz);
			end
			4'd8: begin
				mul_a = $signed({4'd0, acc_q[19:0]});
				mul_b = $signed({2'd0, beta_q});
			end
			4'd9: begin
				mul_a = $signed({5'd0, acc_q[38:20]});
				mul_b = $signed({2'd0, beta_q});
			end
			4'd11: begin
				mul_a = $signed({2'd0, x_q[21:0]});
				mul_b = 18'(EXP_TABLE_ENTRIES);
			end
			4'd12: begin
				mul_a = $signed({2'd0, x_q[43:22]});
				mul_b = 18'(EXP_TABLE_ENTRIES);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 42'(mul_a * mul_b);

	// table index: floor(x*n / 2^44) from two partial products
	logic [35:0] t_sum;
	logic [13:0] idx_full;

	assign t_sum    = 36'(prod_q[35:0]) + 36'(t_q);
	assign idx_full = t_sum[35:22];

	logic load_out;
	assign load_out = (state_q == S_DONE) && (!ovalid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= 16'd10240;
			exch_q <= 4'sd0;
			axis_q <= 4'sd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BETA: beta_q <= cfg.data;
				CFG_EXCH: exch_q <= cfg.data[3:0];
				CFG_AXIS: axis_q <= cfg.data[3:0];
				default:  ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cnt_q    <= '0;
			clr_q    <= '0;
			site_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			ovalid_q <= 1'b0;
			accept_q <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_z_q  <= MAG_W'(SITES * SPIN_ONE);
		end else begin
			// a new result replaces one that is taken in the same cycle
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(SITES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_READ;
						cnt_q   <= '0;
					end
				end
				S_READ: begin
					// centre first, then up, down, left, right
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd1 && mode_q) begin
						accept_q <= 1'b1;
						state_q  <= S_WRITE;
					end else if (cnt_q == 4'd5) begin
						cnt_q   <= '0;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd8 && acc_q <= 0) begin
						// energy does not rise
						accept_q <= 1'b1;
						state_q  <= S_WRITE;
					end else if (cnt_q == 4'd11 && x_q[54:44] != '0) begin
						// argument beyond the table
						accept_q <= 1'b0;
						state_q  <= S_WRITE;
					end else if (cnt_q == 4'd13) begin
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					accept_q <= ({1'b0, uni_q} < rom_q);
					state_q  <= S_WRITE;
				end
				S_WRITE: begin
					if (accept_q) begin
						sum_x_q <= sum_x_q + MAG_W'(dx);
						sum_y_q <= sum_y_q + MAG_W'(dy);
						sum_z_q <= sum_z_q + MAG_W'(dz);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
						if (site_q == ADDR_W'(SITES - 1)) begin
							site_q <= '0;
							row_q  <= '0;
							col_q  <= '0;
						end else begin
							site_q <= site_q + 1'b1;
							if (col_q == ROW_W'(LATTICE_SIDE - 1)) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			nx_q   <= req.prop_x;
			ny_q   <= req.prop_y;
			nz_q   <= req.prop_z;
			uni_q  <= req.uniform;
		end
		if (state_q == S_READ) begin
			case (cnt_q)
				4'd1: begin
					ox_q <= ram_rdata[47:32];
					oy_q <= ram_rdata[31:16];
					oz_q <= ram_rdata[15:0];
				end
				4'd2: begin
					sx_q <= 18'($signed(ram_rdata[47:32]));
					sy_q <= 18'($signed(ram_rdata[31:16]));
					sz_q <= 18'($signed(ram_rdata[15:0]));
				end
				4'd3, 4'd4, 4'd5: begin
					sx_q <= sx_q + 18'($signed(ram_rdata[47:32]));
					sy_q <= sy_q + 18'($signed(ram_rdata[31:16]));
					sz_q <= sz_q + 18'($signed(ram_rdata[15:0]));
				end
				default: ;
			endcase
		end
		if (state_q == S_CALC) begin
			prod_q <= mul_p;
			case (cnt_q)
				4'd1:  ax_q  <= prod_q[21:0];
				4'd2:  ay_q  <= prod_q[21:0];
				4'd3:  bz_q  <= prod_q[22:0];
				4'd4:  acc_q <= -prod_q[39:0];
				4'd5:  acc_q <= acc_q - prod_q[39:0];
				4'd6:  acc_q <= acc_q - prod_q[39:0];
				4'd7:  acc_q <= acc_q - prod_q[39:0];
				4'd9:  xlo_q <= prod_q[35:0];
				4'd10: x_q   <= {prod_q[34:0], 20'd0} + 55'(xlo_q);
				4'd12: t_q   <= prod_q[34:22];
				4'd13: idx_q <= (idx_full >= 14'(EXP_TABLE_ENTRIES))
					? IDX_W'(EXP_TABLE_ENTRIES - 1) : idx_full[IDX_W-1:0];
				default: ;
			endcase
		end
		if (state_q == S_EXP) begin
			rom_q <= exp_rom[idx_q];
		end
		if (load_out) begin
			orow_q  <= 6'(row_q);
			ocol_q  <= 6'(col_q);
			oacc_q  <= accept_q;
			olast_q <= (site_q == ADDR_W'(SITES - 1));
			if (site_q == ADDR_W'(SITES - 1)) begin
				omx_q <= sum_x_q;
				omy_q <= sum_y_q;
				omz_q <= sum_z_q;
			end else begin
				omx_q <= '0;
				omy_q <= '0;
				omz_q <= '0;
			end
		end
	end

	assign rsp.valid      = ovalid_q;
	assign rsp.site_row   = orow_q;
	assign rsp.site_col   = ocol_q;
	assign rsp.accepted   = oacc_q;
	assign rsp.sweep_done = olast_q;
	assign rsp.mag_x      = omx_q;
	assign rsp.mag_y      = omy_q;
	assign rsp.mag_z      = omz_q;

endmodule

// File: rtl/hms_ram.sv
// ----------------------------------------------------------------------------
// hms_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hms_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
